>>> src/hamming_syndrome_correct_defines.svh
// Assertion macros shared by the decoder modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef HAMMING_SYNDROME_CORRECT_DEFINES_SVH
`define HAMMING_SYNDROME_CORRECT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hamming decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hamming decoder check failed");

`endif

>>> src/hsc_pkg.sv
package hsc_pkg;

  localparam int MAX_CODE_BITS = 63;
  localparam int MIN_CODE_BITS = 3;
  localparam int WORD_W = 63;
  localparam int LEN_W  = 6;
  localparam int DATA_W = 57;
  localparam int PAR_W  = 3;
  localparam int SYN_W  = 6;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PAR_W-1:0]  par_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    STAT_NONE          = 2'd0,
    STAT_CORRECTED     = 2'd1,
    STAT_UNCORRECTABLE = 2'd2
  } status_t;

  // Payload after the first stage: masked word, clamped length, parity count.
  typedef struct packed {
    word_t word;
    len_t  n;
    par_t  r;
  } front_t;

  // Payload after the second stage adds the syndrome.
  typedef struct packed {
    word_t word;
    len_t  n;
    par_t  r;
    syn_t  syn;
  } synd_t;

  // Positions whose number has bit i set; they feed syndrome bit i.
  function automatic word_t syn_mask(input int i);
    word_t m;
    m = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

  // Word bit that holds the k-th position which is not a power of two.
  function automatic int data_bit_index(input int k);
    int cnt;
    int idx;
    cnt = 0;
    idx = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (cnt == k) begin
          idx = p - 1;
        end
        cnt++;
      end
    end
    return idx;
  endfunction

endpackage

>>> src/hsc_front.sv
module hsc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  hsc_pkg::word_t received_word,
  input  hsc_pkg::len_t  code_length,
  output logic           out_valid,
  output hsc_pkg::front_t out_data
);
  import hsc_pkg::*;

  len_t   n_clamped;
  par_t   r_next;
  word_t  mask;
  front_t out_next;

  always_comb begin
    if (code_length < LEN_W'(MIN_CODE_BITS)) begin
      n_clamped = LEN_W'(MIN_CODE_BITS);
    end else if ({1'b0, code_length} > (LEN_W+1)'(MAX_CODE_BITS)) begin
      n_clamped = LEN_W'(MAX_CODE_BITS);
    end else begin
      n_clamped = code_length;
    end
  end

  // The parity count is the bit length of n, since 2^r must exceed n.
  always_comb begin
    priority if (n_clamped[5]) begin
      r_next = 3'd6;
    end else if (n_clamped[4]) begin
      r_next = 3'd5;
    end else if (n_clamped[3]) begin
      r_next = 3'd4;
    end else if (n_clamped[2]) begin
      r_next = 3'd3;
    end else begin
      r_next = 3'd2;
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      mask[j] = j < int'(n_clamped);
    end
    out_next.word = received_word & mask;
    out_next.n    = n_clamped;
    out_next.r    = r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

endmodule

>>> src/hsc_syndrome.sv
module hsc_syndrome (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  hsc_pkg::front_t in_data,
  output logic            out_valid,
  output hsc_pkg::synd_t  out_data
);
  import hsc_pkg::*;

  syn_t  syn_next;

  // Each syndrome bit is the parity over the positions carrying that bit.
  for (genvar i = 0; i < SYN_W; i++) begin : g_syn
    assign syn_next[i] = ^(in_data.word & syn_mask(i));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data.word <= in_data.word;
    out_data.n    <= in_data.n;
    out_data.r    <= in_data.r;
    out_data.syn  <= syn_next;
  end

endmodule

>>> src/hsc_correct.sv
`include "hamming_syndrome_correct_defines.svh"

module hsc_correct (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  hsc_pkg::synd_t   in_data,
  output logic             done,
  output hsc_pkg::word_t   corrected_word,
  output hsc_pkg::data_t   data_word,
  output hsc_pkg::len_t    data_length,
  output hsc_pkg::par_t    parity_count,
  output hsc_pkg::syn_t    syndrome,
  output hsc_pkg::status_t status
);
  import hsc_pkg::*;

  status_t status_next;
  word_t   flip;
  word_t   fixed_word;
  data_t   data_next;

  always_comb begin
    if (in_data.syn == '0) begin
      status_next = STAT_NONE;
    end else if (in_data.syn <= in_data.n) begin
      status_next = STAT_CORRECTED;
    end else begin
      status_next = STAT_UNCORRECTABLE;
    end
  end

  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      flip[j] = (status_next == STAT_CORRECTED) && (int'(in_data.syn) == j + 1);
    end
    fixed_word = in_data.word ^ flip;
  end

  // Data positions are fixed; bits past the length are already zero.
  for (genvar k = 0; k < DATA_W; k++) begin : g_data
    assign data_next[k] = fixed_word[data_bit_index(k)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    corrected_word <= fixed_word;
    data_word      <= data_next;
    data_length    <= in_data.n - LEN_W'(in_data.r);
    parity_count   <= in_data.r;
    syndrome       <= in_data.syn;
    status         <= status_next;
  end

  `HSC_ASSERT_SAME(a_corr_in_range, done && status == STAT_CORRECTED,
    syndrome != '0 && int'(syndrome) <= int'(data_length) + int'(parity_count))
  `HSC_ASSERT_SAME(a_uncorr_beyond, done && status == STAT_UNCORRECTABLE,
    int'(syndrome) > int'(data_length) + int'(parity_count))
  `HSC_ASSERT_SAME(a_clean_zero_syn, done && status == STAT_NONE, syndrome == '0)

endmodule

>>> src/hamming_syndrome_correct.sv
// Hamming single-error-correcting decoder.
// A request is one received codeword (received_word, bit j-1 holding position j)
// with its length code_length; it is accepted on a rising edge where start is high
// and busy is low. Lengths below three are taken as three.
// The block is a three-stage pipeline: the first stage clamps the length, masks off
// bits above it and derives the parity count, the second forms the syndrome with
// six XOR trees, and the third flips the erroneous bit and packs the data bits.
// Each request reaches the done strobe through the front, syndrome and correct registers;
// a new request can be accepted in every cycle but during reset, so throughput is one codeword per clock.
// Each result is shown for exactly one cycle with done high; the receiver cannot
// stall, so nothing inside the pipeline ever waits and busy only guards reset.
// status reports no error, a corrected bit, or a syndrome beyond the length, in
// which case the word is returned unchanged apart from masking.
// A synchronous reset clears the valid bits of every stage, so no result appears
// for requests in flight at reset; busy is high while reset is held.
`include "hamming_syndrome_correct_defines.svh"

module hamming_syndrome_correct (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hsc_pkg::word_t   received_word,
  input  hsc_pkg::len_t    code_length,
  output logic             done,
  output hsc_pkg::word_t   corrected_word,
  output hsc_pkg::data_t   data_word,
  output hsc_pkg::len_t    data_length,
  output hsc_pkg::par_t    parity_count,
  output hsc_pkg::syn_t    syndrome,
  output hsc_pkg::status_t status
);
  import hsc_pkg::*;

  logic   accept;
  logic   front_valid;
  front_t front_data;
  logic   synd_valid;
  synd_t  synd_data;

  // The pipeline never backs up, so it only refuses requests during reset.
  assign busy   = rst;
  assign accept = start && !busy;

  hsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .received_word (received_word),
    .code_length   (code_length),
    .out_valid     (front_valid),
    .out_data      (front_data)
  );

  hsc_syndrome u_syndrome (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (synd_valid),
    .out_data  (synd_data)
  );

  hsc_correct u_correct (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (synd_valid),
    .in_data        (synd_data),
    .done           (done),
    .corrected_word (corrected_word),
    .data_word      (data_word),
    .data_length    (data_length),
    .parity_count   (parity_count),
    .syndrome       (syndrome),
    .status         (status)
  );

  // Every accepted request comes out as a done strobe once it has passed all stage registers.
  `HSC_ASSERT_SAME(a_done_latency, 1'b1, done == $past(accept, 3))

endmodule

>>> bench/tb_hamming_syndrome_correct.sv
`timescale 1ns / 1ps

// Self-checking bench for the Hamming single-error-correcting decoder.
// Requests are driven at the rising clock edge with nonblocking assignments.
// A request counts as accepted at an edge where start is high and busy is low.
// The checker samples the same edge, so the expected result for each accepted request
// is computed from the very values that the block latched.
// Results carry a one-cycle done strobe and cannot be held off. Every strobe is
// compared field by field with the oldest pending prediction.
module tb_hamming_syndrome_correct;
  import hsc_pkg::*;

  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 440;
  localparam int STREAM_ITEMS   = 60;
  localparam int DRAIN_CYCLES   = 8;   // more than the pipeline depth
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTED   = 20;

  // One predicted decode, laid out like the result ports.
  typedef struct packed {
    word_t   corrected;
    data_t   data;
    len_t    dlen;
    par_t    par;
    syn_t    syn;
    status_t stat;
  } decode_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  word_t   received_word = '0;
  len_t    code_length = '0;
  logic    busy;
  logic    done;
  word_t   corrected_word;
  data_t   data_word;
  len_t    data_length;
  par_t    parity_count;
  syn_t    syndrome;
  status_t status;

  decode_t pending_decodes[$];
  int      error_count = 0;
  int      request_count = 0;
  int      result_count = 0;
  int      status_seen[3] = '{0, 0, 0};
  int      cycle_count = 0;

  hamming_syndrome_correct u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .received_word  (received_word),
    .code_length    (code_length),
    .done           (done),
    .corrected_word (corrected_word),
    .data_word      (data_word),
    .data_length    (data_length),
    .parity_count   (parity_count),
    .syndrome       (syndrome),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Length after the block's clamping: below three is taken as three.
  function automatic int clamp_len(input len_t len);
    int n;
    n = len;
    if (n < MIN_CODE_BITS) n = MIN_CODE_BITS;
    if (n > MAX_CODE_BITS) n = MAX_CODE_BITS;
    return n;
  endfunction

  // Predicts the full decode of one received word.
  function automatic decode_t predict_decode(input word_t rx, input len_t len);
    decode_t d;
    word_t   w;
    int      n;
    int      r;
    int      syn;
    int      k;
    n = clamp_len(len);
    w = '0;
    for (int p = 1; p <= n; p++) w[p-1] = rx[p-1];
    r = 0;
    while ((1 << r) < n + 1) r++;
    syn = 0;
    for (int p = 1; p <= n; p++) begin
      if (w[p-1]) syn ^= p;
    end
    if (syn == 0) begin
      d.stat = STAT_NONE;
    end else if (syn <= n) begin
      w[syn-1] = ~w[syn-1];
      d.stat = STAT_CORRECTED;
    end else begin
      // The syndrome points past the end of the word, so nothing is flipped.
      d.stat = STAT_UNCORRECTABLE;
    end
    d.data = '0;
    k = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        d.data[k] = w[p-1];
        k++;
      end
    end
    d.corrected = w;
    d.dlen = len_t'(n - r);
    d.par = par_t'(r);
    d.syn = syn_t'(syn);
    return d;
  endfunction

  function automatic word_t rand_word();
    return word_t'({$urandom, $urandom});
  endfunction

  // Builds a valid codeword of n bits from the payload, then fills the ignored bits
  // above the length with noise. The parity positions always lie within n.
  function automatic word_t build_codeword(input logic [63:0] payload, input int n);
    word_t w;
    word_t junk;
    int    k;
    int    s;
    w = '0;
    k = 0;
    s = 0;
    for (int p = 1; p <= n; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = payload[k];
        if (w[p-1]) s ^= p;
        k++;
      end
    end
    for (int i = 0; i < 6; i++) begin
      if (((s >> i) & 1) != 0) w[(1 << i) - 1] = 1'b1;
    end
    junk = rand_word();
    for (int p = n + 1; p <= WORD_W; p++) w[p-1] = junk[p-1];
    return w;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int random_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Presents one request and returns at the edge that accepts it. start is left
  // high so that a following request can go out in the very next cycle.
  task automatic send_request(input word_t rx, input len_t len);
    start <= 1'b1;
    received_word <= rx;
    code_length <= len;
    @(posedge clk);
    while (busy) @(posedge clk);
    request_count++;
  endtask

  // Drops start for a number of cycles and puts noise on the payload meanwhile,
  // which the block must ignore.
  task automatic pause_requests(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      received_word <= rand_word();
      code_length <= len_t'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    error_count++;
    if (error_count <= MAX_REPORTED) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
    end
  endtask

  // Prediction and comparison share one process on the rising edge. Both read the
  // values from before the edge, so acceptance and results are seen exactly as the
  // block sees them.
  always @(posedge clk) begin : result_checker
    decode_t want;
    if (!rst && start && !busy) begin
      pending_decodes.push_back(predict_decode(received_word, code_length));
    end
    if (!rst && done) begin
      if (pending_decodes.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, expected none actual syndrome %h",
                 $time, syndrome);
      end else begin
        want = pending_decodes.pop_front();
        result_count++;
        if (want.stat <= STAT_UNCORRECTABLE) status_seen[want.stat]++;
        if (corrected_word !== want.corrected)
          note_mismatch("corrected_word", 64'(want.corrected), 64'(corrected_word));
        if (data_word !== want.data)
          note_mismatch("data_word", 64'(want.data), 64'(data_word));
        if (data_length !== want.dlen)
          note_mismatch("data_length", 64'(want.dlen), 64'(data_length));
        if (parity_count !== want.par)
          note_mismatch("parity_count", 64'(want.par), 64'(parity_count));
        if (syndrome !== want.syn)
          note_mismatch("syndrome", 64'(want.syn), 64'(syndrome));
        if (status !== want.stat)
          note_mismatch("status", 64'(want.stat), 64'(status));
      end
    end
  end

  // Lengths at both ends and below the lower end, with all-zero and all-one words.
  // Lengths zero to two must behave as a length of three.
  task automatic test_length_extremes();
    send_request('0, len_t'(0));
    pause_requests(random_gap());
    send_request('1, len_t'(0));
    send_request('1, len_t'(1));
    pause_requests(random_gap());
    send_request('1, len_t'(2));
    send_request('1, len_t'(3));
    send_request('0, len_t'(63));
    pause_requests(random_gap());
    send_request('1, len_t'(63));
    send_request('1, len_t'(7));
  endtask

  // Clean codewords and single-bit errors at the first, a parity, a data and the last position.
  task automatic test_single_errors();
    word_t w;
    w = build_codeword({$urandom, $urandom}, 63);
    send_request(w, len_t'(63));
    send_request(w ^ word_t'(1), len_t'(63));
    pause_requests(random_gap());
    send_request(w ^ (word_t'(1) << 31), len_t'(63));
    send_request(w ^ (word_t'(1) << 62), len_t'(63));
    w = build_codeword(64'hFFFF_FFFF_FFFF_FFFF, 7);
    send_request(w, len_t'(7));
    send_request(w ^ (word_t'(1) << 4), len_t'(7));
    pause_requests(random_gap());
    // Positions one and two set at length three give syndrome three, the last bit.
    send_request(word_t'(3), len_t'(3));
  endtask

  // Syndromes that point past the length must leave the masked word unchanged.
  task automatic test_syndrome_beyond_length();
    // Positions three and four at length five give syndrome seven.
    send_request(word_t'('h0C) | (rand_word() & ~word_t'('h1F)), len_t'(5));
    pause_requests(random_gap());
    // Positions seven and eight at length twelve give syndrome fifteen.
    send_request(word_t'('hC0), len_t'(12));
    // Positions five and two at length six give syndrome seven.
    send_request(word_t'('h12), len_t'(6));
  endtask

  // One random request: mostly well-formed codewords, clean or with one error, some
  // with two errors, and some raw noise. Lengths are spread with weight on the ends.
  task automatic send_random_request();
    int    sel;
    int    n;
    int    e1;
    int    e2;
    len_t  len;
    word_t w;
    sel = $urandom_range(0, 99);
    if (sel < 5) len = len_t'($urandom_range(0, 2));
    else if (sel < 15) len = len_t'(63);
    else if (sel < 25) len = len_t'($urandom_range(3, 7));
    else len = len_t'($urandom_range(3, 63));
    n = clamp_len(len);
    w = build_codeword({$urandom, $urandom}, n);
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      // Clean codeword.
    end else if (sel < 65) begin
      e1 = $urandom_range(1, n);
      w[e1-1] = ~w[e1-1];
    end else if (sel < 85) begin
      e1 = $urandom_range(1, n);
      e2 = $urandom_range(1, n - 1);
      if (e2 >= e1) e2++;
      w[e1-1] = ~w[e1-1];
      w[e2-1] = ~w[e2-1];
    end else begin
      w = rand_word();
    end
    send_request(w, len);
  endtask

  // A long stretch with a request in every cycle.
  task automatic test_back_to_back();
    for (int i = 0; i < STREAM_ITEMS; i++) send_random_request();
  endtask

  // Random traffic with random idle gaps between requests.
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_random_request();
      pause_requests(random_gap());
    end
  endtask

  // Ends the run if the traffic stalls; the limit is far above any correct run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results pending.",
             cycle_count, pending_decodes.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_length_extremes();
    test_single_errors();
    test_syndrome_beyond_length();
    test_back_to_back();
    test_random_traffic();
    start <= 1'b0;
    // Wait for every prediction to be matched, then let the drain period run so that a
    // stray extra strobe is still caught.
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Decoded %0d requests, lengths 0 to 63, with idle gaps and back-to-back runs.",
             request_count);
    $display("Results checked: %0d clean, %0d corrected, %0d uncorrectable; %0d mismatches.",
             status_seen[0], status_seen[1], status_seen[2], error_count);
    if (error_count == 0 && result_count == request_count) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/hsc_pkg.sv
src/hsc_front.sv
src/hsc_syndrome.sv
src/hsc_correct.sv
src/hamming_syndrome_correct.sv
bench/tb_hamming_syndrome_correct.sv
